[rtl/ecg_heart_rate_detector_unit_macros.svh]
// ----------------------------------------------------------------------------
// ECG heart rate detector assertion macros
// Short forms for the clocked checks used by the detector top level.
// ----------------------------------------------------------------------------
`ifndef ECG_HEART_RATE_DETECTOR_UNIT_MACROS_SVH
`define ECG_HEART_RATE_DETECTOR_UNIT_MACROS_SVH

// Checks that an expression holds at every clock edge out of reset.
`define ECGHRD_CHK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ECGHRD_CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define ECGHRD_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ecghrd_pkg.sv]
// ----------------------------------------------------------------------------
// ECG heart rate detector package
// Shared constants, payload types and sequencer states of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ecghrd_pkg;

  localparam int WINDOW_DEPTH = 128;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int HIST_LAST    = WINDOW_DEPTH - 2;
  localparam int TICK_W       = 20;

  localparam int              DIV10_SHIFT = 20;
  localparam logic [16:0]     DIV10_RECIP = 17'd104858;
  localparam logic [15:0]     BPM_NUM     = 16'd60000;
  localparam logic [7:0]      BPM_MAX     = 8'd200;
  localparam logic [7:0]      BPM_MIN     = 8'd30;
  localparam logic [7:0]      PERIOD_RST  = 8'd4;
  localparam logic [12:0]     JUMP_RST    = 13'd8191;
  localparam logic [TICK_W-1:0] TICK_MAX  = {TICK_W{1'b1}};

  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_JUMP   = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [23:0]        status_word;
  } in_beat_t;

  typedef struct packed {
    logic signed [13:0] display_value;
    logic [7:0]         bpm;
    logic               beat_flag;
    logic               lead_off;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BASE, S_DIFF, S_MUL, S_VAL, S_SCAN, S_THR,
    S_TMUL, S_TFIN, S_BEAT, S_DIV, S_OUT
  } seq_state_t;

endpackage

`default_nettype wire

[rtl/ecg_heart_rate_detector_unit.sv]
// ----------------------------------------------------------------------------
// ECG heart rate detector
// Baseline removal, adaptive threshold and beat-to-beat heart rate per sample.
// ----------------------------------------------------------------------------
// One sample beat in gives one result beat out. A new sample is accepted only
// after the sequencer has returned to idle from the previous one, and its
// result is registered in the output state. A sample that completes the
// 128-entry window adds the read scan of the window memory and the threshold
// update, and a second rising crossing adds the bit-serial rate division. The
// window scan through the single read port of the window memory sets the worst
// case. A stalled result holds the sequencer until it is taken. The user must
// write configuration only while no sample is in flight; the block itself does
// not enforce this.
`default_nettype none

`include "ecg_heart_rate_detector_unit_macros.svh"

module ecg_heart_rate_detector_unit
  import ecghrd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  seq_state_t state_r, state_nxt;

  logic signed [15:0] x_r, x_nxt;
  logic               lead_r, lead_nxt;
  logic signed [23:0] sum_r, sum_nxt;
  logic [WIN_AW-1:0]  hptr_r, hptr_nxt;
  logic               hwrap_r, hwrap_nxt;
  logic [17:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [34:0]        prod_r, prod_nxt;
  logic signed [13:0] cur_r, cur_nxt;
  logic [WIN_AW-1:0]  fidx_r, fidx_nxt;
  logic               filled_r, filled_nxt;
  logic [13:0]        jl_r, jl_nxt;
  logic [12:0]        init_r, init_nxt;
  logic [7:0]         period_r, period_nxt;
  logic signed [14:0] thr_r, thr_nxt;
  logic               above_r, above_nxt;
  logic               parity_r, parity_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [TICK_W-1:0]  first_r, first_nxt;
  logic [7:0]         rate_r, rate_nxt;
  logic signed [13:0] mx_r, mx_nxt;
  logic signed [13:0] mn_r, mn_nxt;
  logic [WIN_AW:0]    scan_cnt_r, scan_cnt_nxt;
  logic               scan_vld_r, scan_vld_nxt;
  logic               scan_seen_r, scan_seen_nxt;
  logic               beat_r, beat_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic               hist_re, hist_we;
  logic [15:0]        hist_rdata;
  logic               win_re, win_we;
  logic [WIN_AW-1:0]  win_raddr;
  logic [13:0]        win_rdata;
  logic               div_start, div_done;
  logic [27:0]        div_divisor;
  logic [15:0]        div_quo;

  logic               accept, out_free, scan_issue, scan_end, store, beat, start_div;
  logic signed [15:0] old_x;
  logic signed [16:0] base;
  logic signed [17:0] diff;
  logic [14:0]        q15;
  logic signed [13:0] val;
  logic signed [14:0] delta, lim;
  logic signed [14:0] mm_sum;
  logic signed [17:0] mm_sum8;
  logic signed [14:0] mm_diff;
  logic signed [13:0] wd;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign scan_issue = (state_r == S_SCAN) && (scan_cnt_r < (WIN_AW+1)'(WINDOW_DEPTH));
  assign scan_end   = (state_r == S_SCAN) && scan_vld_r && !scan_issue;

  always_comb begin
    q15   = prod_r[DIV10_SHIFT+14:DIV10_SHIFT];
    val   = neg_r ? -14'(q15) : 14'(q15);
    lim   = filled_r ? $signed({1'b0, jl_r}) : $signed({2'b00, init_r});
    delta = $signed({val[13], val}) - $signed({cur_r[13], cur_r});
    store = delta < lim;
    beat  = !above_r && ($signed({cur_r[13], cur_r}) > thr_r);
    start_div = (state_r == S_BEAT) && beat && parity_r && (tick_r > first_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_BASE;
      S_BASE: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_VAL;
      S_VAL: begin
        if (store && (fidx_r == WIN_AW'(WINDOW_DEPTH - 1))) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_BEAT;
        end
      end
      S_SCAN: if (scan_end) state_nxt = S_THR;
      S_THR:  state_nxt = S_TMUL;
      S_TMUL: state_nxt = S_TFIN;
      S_TFIN: state_nxt = S_BEAT;
      S_BEAT: state_nxt = start_div ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    x_nxt         = x_r;
    lead_nxt      = lead_r;
    sum_nxt       = sum_r;
    hptr_nxt      = hptr_r;
    hwrap_nxt     = hwrap_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    fidx_nxt      = fidx_r;
    filled_nxt    = filled_r;
    jl_nxt        = jl_r;
    thr_nxt       = thr_r;
    above_nxt     = above_r;
    parity_nxt    = parity_r;
    tick_nxt      = tick_r;
    first_nxt     = first_r;
    rate_nxt      = rate_r;
    mx_nxt        = mx_r;
    mn_nxt        = mn_r;
    scan_cnt_nxt  = scan_cnt_r;
    scan_vld_nxt  = 1'b0;
    scan_seen_nxt = scan_seen_r;
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    hist_re       = 1'b0;
    hist_we       = 1'b0;
    win_re        = 1'b0;
    win_we        = 1'b0;
    win_raddr     = scan_cnt_r[WIN_AW-1:0];
    div_start     = 1'b0;
    div_divisor   = 28'((tick_r - first_r) * period_r);
    old_x         = hwrap_r ? $signed(hist_rdata) : 16'sd0;
    base          = 17'(sum_r / WINDOW_DEPTH);
    diff          = 18'(x_r) - 18'(base);
    wd            = $signed(win_rdata);
    mm_sum        = 15'(mx_r) + 15'(mn_r);
    mm_sum8       = 18'(mm_sum) <<< 3;
    mm_diff       = 15'(mx_r) - 15'(mn_r);
    init_nxt      = init_r;
    period_nxt    = period_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_PERIOD: period_nxt = cfg_wdata[7:0];
        REG_JUMP:   init_nxt   = cfg_wdata;
        default:    init_nxt   = init_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          lead_nxt = in_data.status_word[19:17] != 3'b000;
          x_nxt    = lead_nxt ? 16'sd0 : in_data.sample;
          hist_re  = 1'b1;
        end
      end
      S_BASE: begin
        hist_we = 1'b1;
        sum_nxt = sum_r + 24'(x_r) - 24'(old_x);
        if (hptr_r == WIN_AW'(HIST_LAST)) begin
          hptr_nxt  = '0;
          hwrap_nxt = 1'b1;
        end else begin
          hptr_nxt = hptr_r + 1'b1;
        end
      end
      S_DIFF: begin
        neg_nxt = diff < 0;
        mag_nxt = neg_nxt ? 18'(-diff) : 18'(diff);
      end
      S_MUL, S_TMUL: begin
        prod_nxt = 35'(mag_r * DIV10_RECIP);
      end
      S_VAL: begin
        cur_nxt = val;
        if (store) begin
          win_we = 1'b1;
          if (fidx_r == WIN_AW'(WINDOW_DEPTH - 1)) begin
            fidx_nxt      = '0;
            scan_cnt_nxt  = '0;
            scan_seen_nxt = 1'b0;
          end else begin
            fidx_nxt = fidx_r + 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          win_re       = 1'b1;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          scan_vld_nxt = 1'b1;
        end
        if (scan_vld_r) begin
          scan_seen_nxt = 1'b1;
          if (!scan_seen_r) begin
            mx_nxt = wd;
            mn_nxt = wd;
          end else begin
            if (wd > mx_r) mx_nxt = wd;
            if (wd < mn_r) mn_nxt = wd;
          end
        end
      end
      S_THR: begin
        neg_nxt    = mm_sum8 < 0;
        mag_nxt    = neg_nxt ? 18'(-mm_sum8) : 18'(mm_sum8);
        jl_nxt     = 14'(mm_diff >>> 1);
        filled_nxt = 1'b1;
      end
      S_TFIN: begin
        thr_nxt = neg_r ? -$signed(q15) : $signed(q15);
      end
      S_BEAT: begin
        beat_nxt  = beat;
        above_nxt = $signed({cur_r[13], cur_r}) > thr_r;
        tick_nxt  = (tick_r < TICK_MAX) ? tick_r + 1'b1 : tick_r;
        if (beat) begin
          parity_nxt = !parity_r;
          if (!parity_r) begin
            first_nxt = tick_r;
          end else begin
            tick_nxt = TICK_W'(1);
          end
        end
        div_start = start_div;
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quo > 16'(BPM_MAX)) begin
            rate_nxt = BPM_MAX;
          end else if (div_quo < 16'(BPM_MIN)) begin
            rate_nxt = BPM_MIN;
          end else begin
            rate_nxt = div_quo[7:0];
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.display_value = cur_r;
          out_data_nxt.bpm           = rate_r;
          out_data_nxt.beat_flag     = beat_r;
          out_data_nxt.lead_off      = lead_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      hptr_r      <= '0;
      hwrap_r     <= 1'b0;
      cur_r       <= '0;
      fidx_r      <= '0;
      filled_r    <= 1'b0;
      init_r      <= JUMP_RST;
      period_r    <= PERIOD_RST;
      thr_r       <= '0;
      above_r     <= 1'b0;
      parity_r    <= 1'b0;
      tick_r      <= '0;
      first_r     <= '0;
      rate_r      <= '0;
      scan_cnt_r  <= '0;
      scan_vld_r  <= 1'b0;
      scan_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      hptr_r      <= hptr_nxt;
      hwrap_r     <= hwrap_nxt;
      cur_r       <= cur_nxt;
      fidx_r      <= fidx_nxt;
      filled_r    <= filled_nxt;
      init_r      <= init_nxt;
      period_r    <= period_nxt;
      thr_r       <= thr_nxt;
      above_r     <= above_nxt;
      parity_r    <= parity_nxt;
      tick_r      <= tick_nxt;
      first_r     <= first_nxt;
      rate_r      <= rate_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      scan_vld_r  <= scan_vld_nxt;
      scan_seen_r <= scan_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    lead_r     <= lead_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    prod_r     <= prod_nxt;
    jl_r       <= jl_nxt;
    mx_r       <= mx_nxt;
    mn_r       <= mn_nxt;
    beat_r     <= beat_nxt;
    out_data_r <= out_data_nxt;
  end

  ecghrd_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(16)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hptr_r),
    .wdata (x_r),
    .re    (hist_re),
    .raddr (hptr_r),
    .rdata (hist_rdata)
  );

  ecghrd_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(14)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (fidx_r),
    .wdata (val),
    .re    (win_re),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  ecghrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ECGHRD_CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Accepted a second sample while busy.")
  `ECGHRD_CHK_IMPL(a_bpm_range, out_valid && (out_data.bpm != 8'd0), (out_data.bpm >= BPM_MIN) && (out_data.bpm <= BPM_MAX), "Heart rate outside its clamp range.")
  `ECGHRD_CHK_IMPL(a_thr_after_fill, state_r == S_TFIN, filled_r, "Threshold update without a filled window.")
  `ECGHRD_CHK_IMPL(a_div_idle_state, div_done, state_r == S_DIV, "Rate division finished outside its wait state.")

endmodule

`default_nettype wire

[rtl/ecghrd_ram.sv]
// ----------------------------------------------------------------------------
// ECG heart rate detector RAM
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ecghrd_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/ecghrd_div.sv]
// ----------------------------------------------------------------------------
// ECG heart rate detector rate divider
// Restoring divider that forms 60000 over the beat interval, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ecghrd_div
  import ecghrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [27:0] divisor,
  output logic             done,
  output logic [15:0]      quotient
);

  logic [28:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [27:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [28:0] rem_sh;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[27:0], quo_r[15]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = BPM_NUM;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// ECG heart rate detector testbench
// Drives filtered samples with random idling and back-pressure, predicts
// every result with an independent behavioral model, and checks each result
// field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import ecghrd_pkg::*;

class hr_scoreboard;
  logic signed [15:0] hist [WINDOW_DEPTH];
  int                 win [WINDOW_DEPTH];
  int                 fill_idx;
  int                 cur_val;
  int                 prev_val;
  int                 jump_lim;
  int                 thresh;
  bit                 above;
  bit                 parity;
  int unsigned        ticks;
  int unsigned        first_tick;
  int unsigned        rate;
  bit                 filled;
  int unsigned        period;
  int unsigned        init_jump;
  out_beat_t          pending [$];
  int                 mismatches;

  function new();
    foreach (hist[i]) hist[i] = '0;
    foreach (win[i]) win[i] = 0;
    fill_idx = 0;
    cur_val = 0;
    prev_val = 0;
    thresh = 0;
    above = 0;
    parity = 0;
    ticks = 0;
    first_tick = 0;
    rate = 0;
    filled = 0;
    period = PERIOD_RST;
    init_jump = JUMP_RST;
    jump_lim = init_jump;
    mismatches = 0;
  endfunction

  function void write_reg(logic [0:0] idx, logic [12:0] data);
    if (idx == REG_PERIOD) begin
      period = data[7:0];
    end else begin
      init_jump = data;
      if (!filled) jump_lim = init_jump;
    end
  endfunction

  function void note_sample(in_beat_t b);
    int        x;
    int        total;
    int        mx;
    int        mn;
    int unsigned gap;
    int unsigned r;
    bit        lead;
    bit        was_above;
    bit        hit;
    out_beat_t res;
    lead = b.status_word[19:17] != 3'b0;
    x = lead ? 0 : int'(b.sample);
    for (int i = WINDOW_DEPTH - 1; i > 0; i--) hist[i] = hist[i - 1];
    hist[0] = 16'(x);
    total = 0;
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) total += hist[i];
    prev_val = cur_val;
    cur_val = (x - total / WINDOW_DEPTH) / 10;
    if (cur_val - prev_val < jump_lim) begin
      win[fill_idx] = cur_val;
      fill_idx++;
    end
    if (fill_idx >= WINDOW_DEPTH) begin
      fill_idx = 0;
      mx = win[0];
      mn = win[0];
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        if (win[i] > mx) mx = win[i];
        if (win[i] < mn) mn = win[i];
      end
      thresh = (mx + mn) * 8 / 10;
      jump_lim = (mx - mn) / 2;
      filled = 1;
    end
    was_above = above;
    above = cur_val > thresh;
    hit = !was_above && above;
    if (hit) begin
      parity = !parity;
      if (parity) begin
        first_tick = ticks;
      end else begin
        gap = ticks;
        ticks = 0;
        if (gap > first_tick) begin
          gap = (gap - first_tick) * period;
          r = (gap == 0) ? 200 : 60000 / gap;
          if (r > 200) r = 200;
          if (r < 30) r = 30;
          rate = r;
        end
      end
    end
    if (ticks < 32'hFFFFF) ticks++;
    res.display_value = cur_val[13:0];
    res.bpm = rate[7:0];
    res.beat_flag = hit;
    res.lead_off = lead;
    pending.push_back(res);
  endfunction

  function void check_result(out_beat_t got);
    out_beat_t exp_res;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_res = pending.pop_front();
    if (got.display_value !== exp_res.display_value || got.bpm !== exp_res.bpm ||
        got.beat_flag !== exp_res.beat_flag || got.lead_off !== exp_res.lead_off) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: value %0d/%0d bpm %0d/%0d beat %b/%b lead %b/%b (exp/act)",
                 exp_res.display_value, got.display_value, exp_res.bpm, got.bpm,
                 exp_res.beat_flag, got.beat_flag, exp_res.lead_off, got.lead_off);
    end
  endfunction
endclass

module tb_top;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_PERIOD;
  logic [12:0] cfg_wdata = '0;

  hr_scoreboard rate_sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 1'b0;
  int  quiet_cycles = 0;
  int  phase_no = 0;

  always #5 clk = ~clk;

  ecg_heart_rate_detector_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) rate_sb.check_result(out_data);
    if (rst_n && in_valid && in_ready) rate_sb.note_sample(in_data);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_sample(logic [15:0] smp, logic [23:0] st);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {smp, st};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [12:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rate_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // A synthetic heartbeat: flat noise with a tall spike of three samples every beat_gap samples.
  task automatic send_train(int count, int beat_gap, int amp, int noise);
    logic [23:0] st;
    int          v;
    for (int i = 0; i < count; i++) begin
      v = $urandom_range(2 * noise) - noise;
      if (i % beat_gap < 3) v += amp;
      st = $urandom;
      if ($urandom_range(99) >= 3) st[19:17] = 3'b000;
      send_sample(v[15:0], st);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(16'sh7FFF, 24'h000000);
    send_sample(16'sh8000, 24'h000000);
    send_sample(16'sh7FFF, 24'hFFFFFF);
    send_sample(16'h0000, 24'h020000);
    send_sample(16'h5555, 24'h040000);
    send_sample(16'hAAAA, 24'h080000);
    send_sample(16'hFFFF, 24'hF1FFFF);
    send_sample(16'sh8000, 24'h0E0000);
    send_sample(16'sh7FFF, 24'h01FFFF);
    send_sample(16'sh8000, 24'h000000);
    drain();
    write_reg(REG_JUMP, 13'd0);
    send_sample(16'sh1000, 24'h0);
    send_sample(16'sh0800, 24'h0);
    drain();
    write_reg(REG_JUMP, 13'd40);
    write_reg(REG_PERIOD, 13'd0);
    send_sample(16'sh0500, 24'h0);
    drain();

    for (phase_no = 0; phase_no < 3; phase_no++) begin
      send_idle_pct = (phase_no == 0) ? 29 : (phase_no == 1) ? 81 : 0;
      recv_idle_pct = (phase_no == 0) ? 81 : (phase_no == 1) ? 29 : 0;
      case (phase_no)
        0: begin
          write_reg(REG_PERIOD, 13'd255);
          write_reg(REG_JUMP, 13'd8191);
        end
        1: begin
          write_reg(REG_PERIOD, 13'd1);
          write_reg(REG_JUMP, 13'd300);
        end
        default: begin
          write_reg(REG_PERIOD, 13'd4);
          write_reg(REG_JUMP, 13'($urandom_range(8191)));
        end
      endcase
      if (phase_no == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk);
            hold_off = 1'b0;
          end
          send_train(20, 9, 4000, 50);
        join
      end
      send_train(130, 25 + 10 * phase_no, 3000 + $urandom_range(20000), 200);
      for (int i = 0; i < 10; i++) send_sample(16'($urandom), 24'($urandom));
      drain();
    end

    if (rate_sb.mismatches == 0 && rate_sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
